// ----- hw/rtl/packet_deframer_with_dedupe_macros.svh -----
// Assertion macros for the deframer's checker file (pdd_checker.sv).
// Expects signals named clk and rst_n in the scope of use.
`ifndef PACKET_DEFRAMER_WITH_DEDUPE_MACROS_SVH
`define PACKET_DEFRAMER_WITH_DEDUPE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PDD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PDD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pdd_pkg.sv -----
// Package for the packet deframer: result types, kind codes, header layout.
// No dependencies; used by every module of the block.
package pdd_pkg;

    localparam int DEF_WINDOW_DEPTH = 32;
    localparam int FIFO_DEPTH       = 4;

    localparam logic [3:0] POS_STATUS  = 4'd0;
    localparam logic [3:0] POS_SIZE_HI = 4'd9;
    localparam logic [3:0] POS_SIZE_LO = 4'd10;
    localparam logic [3:0] HEADER_LEN  = 4'd11;

    localparam logic [7:0] STATUS_KEEPALIVE = 8'd0;
    localparam logic [7:0] STATUS_DATA      = 8'd1;
    localparam logic [7:0] STATUS_ACCEPT    = 8'd2;
    localparam logic [7:0] STATUS_CHECK     = 8'd3;

    typedef enum logic [2:0] {
        KIND_PAYLOAD   = 3'd0,
        KIND_ACK       = 3'd1,
        KIND_KEEPALIVE = 3'd2,
        KIND_NEW       = 3'd3,
        KIND_DUP       = 3'd4,
        KIND_UNKNOWN   = 3'd5
    } pdd_kind_t;

    typedef struct packed {
        pdd_kind_t   kind;
        logic [7:0]  status;
        logic [63:0] id;
        logic [7:0]  data;
        logic        last;
    } pdd_result_t;

    // Up to two results per accepted byte.
    typedef struct packed {
        logic [1:0]  count;
        pdd_result_t e0;
        pdd_result_t e1;
    } pdd_push_t;

    typedef struct packed {
        logic        record;
        logic [63:0] id;
    } pdd_win_req_t;

endpackage

// ----- hw/rtl/pdd_window.sv -----
// Window of recently seen message ids: parallel lookup, ring replacement.
// Depends on pdd_pkg.
module pdd_window
    import pdd_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  pdd_win_req_t win_req,
    output logic         hit
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    logic [63:0]             ids_reg [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [SLOT_W-1:0]       slot_next;

    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (valid_reg[i] && (ids_reg[i] == win_req.id))
            begin
                hit = 1'b1;
            end
        end
        if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else if (win_req.record)
        begin
            valid_reg[slot_reg] <= 1'b1;
            slot_reg            <= slot_next;
        end
    end

    // id storage carries no reset; valid bits gate it
    always_ff @(posedge clk)
    begin
        if (win_req.record)
        begin
            ids_reg[slot_reg] <= win_req.id;
        end
    end

endmodule

// ----- hw/rtl/pdd_parser.sv -----
// Header/payload parser: tracks byte position, builds the header fields,
// picks the verdict and emits up to two results per beat. Depends on pdd_pkg.
module pdd_parser
    import pdd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   rx_byte,
    input  logic         win_hit,
    output pdd_win_req_t win_req,
    output pdd_push_t    push
);

    logic [3:0]  pos_reg,       pos_next;
    logic [7:0]  status_reg,    status_next;
    logic [63:0] id_reg,        id_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        fwd_reg,       fwd_next;
    pdd_kind_t   verdict_reg,   verdict_next;

    logic [15:0] rem_dec;
    logic [15:0] rem_full;
    logic        last_beat;
    logic        is_new;
    pdd_kind_t   verdict_sel;
    pdd_result_t verdict_res;
    pdd_result_t pending_res;
    pdd_result_t payload_res;

    always_comb
    begin
        rem_dec   = remaining_reg - 16'd1;
        rem_full  = {remaining_reg[15:8], rx_byte};
        last_beat = (rem_dec == 16'd0);
        is_new    = 1'b0;

        case (status_reg)
            STATUS_ACCEPT:    verdict_sel = KIND_ACK;
            STATUS_KEEPALIVE: verdict_sel = KIND_KEEPALIVE;
            STATUS_DATA,
            STATUS_CHECK:
            begin
                is_new      = !win_hit;
                verdict_sel = win_hit ? KIND_DUP : KIND_NEW;
            end
            default:          verdict_sel = KIND_UNKNOWN;
        endcase

        verdict_res = '{kind: verdict_sel, status: status_reg, id: id_reg,
                        data: 8'd0, last: 1'b0};
        pending_res = '{kind: verdict_reg, status: status_reg, id: id_reg,
                        data: 8'd0, last: 1'b0};
        payload_res = '{kind: KIND_PAYLOAD, status: status_reg, id: id_reg,
                        data: rx_byte, last: last_beat};

        pos_next       = pos_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        remaining_next = remaining_reg;
        fwd_next       = fwd_reg;
        verdict_next   = verdict_reg;
        win_req.record = 1'b0;
        win_req.id     = id_reg;
        push           = '0;

        if (accept)
        begin
            if (pos_reg >= HEADER_LEN)
            begin
                remaining_next = rem_dec;
                if (fwd_reg)
                begin
                    push.e0    = payload_res;
                    push.e1    = pending_res;
                    push.count = last_beat ? 2'd2 : 2'd1;
                end
                else if (last_beat)
                begin
                    push.e0    = pending_res;
                    push.count = 2'd1;
                end
                if (last_beat)
                begin
                    pos_next = POS_STATUS;
                end
            end
            else
            begin
                case (pos_reg)
                    POS_STATUS:
                    begin
                        status_next    = rx_byte;
                        id_next        = '0;
                        remaining_next = '0;
                        fwd_next       = 1'b0;
                        verdict_next   = KIND_PAYLOAD;
                        pos_next       = pos_reg + 4'd1;
                    end
                    POS_SIZE_HI:
                    begin
                        remaining_next = {rx_byte, 8'd0};
                        pos_next       = pos_reg + 4'd1;
                    end
                    POS_SIZE_LO:
                    begin
                        remaining_next = rem_full;
                        verdict_next   = verdict_sel;
                        fwd_next       = is_new;
                        win_req.record = is_new;
                        if (rem_full == 16'd0)
                        begin
                            push.e0    = verdict_res;
                            push.count = 2'd1;
                            pos_next   = POS_STATUS;
                        end
                        else
                        begin
                            pos_next = HEADER_LEN;
                        end
                    end
                    default:
                    begin
                        // id bytes, big-endian
                        id_next  = {id_reg[55:0], rx_byte};
                        pos_next = pos_reg + 4'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_STATUS;
            status_reg    <= '0;
            id_reg        <= '0;
            remaining_reg <= '0;
            fwd_reg       <= 1'b0;
            verdict_reg   <= KIND_PAYLOAD;
        end
        else
        begin
            pos_reg       <= pos_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
            remaining_reg <= remaining_next;
            fwd_reg       <= fwd_next;
            verdict_reg   <= verdict_next;
        end
    end

endmodule

// ----- hw/rtl/pdd_out_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on pdd_pkg.
module pdd_out_fifo
    import pdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdd_push_t   push,
    input  logic        res_stall,
    output logic        res_valid,
    output pdd_result_t head,
    output logic        full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    pdd_result_t      mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    always_comb
    begin
        res_valid   = (count_reg != '0);
        head        = mem_reg[rd_ptr_reg];
        // room for two is kept so a payload-plus-verdict beat always fits
        full        = (count_reg > CNT_W'(FIFO_DEPTH - 2));
        pop         = res_valid && !res_stall;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.e1;
        end
    end

endmodule

// ----- hw/rtl/packet_deframer_with_dedupe.sv -----
// Packet deframer with duplicate-id suppression (top level).
// Uses pdd_pkg, pdd_parser, pdd_window and pdd_out_fifo.
//
// Usage:
//   rx channel  : one link byte per beat (rx_byte), rx_valid / rx_stall.
//   res channel : one result per beat (result_kind, packet_status,
//                 message_id, payload_byte, payload_last), res_valid / res_stall.
//   Each packet is an 11-byte header (status, 64-bit BE id, 16-bit BE size)
//   followed by the payload. Forwarded payload bytes come out as kind 0;
//   one verdict closes each packet (with the last header byte when the
//   payload is empty, else right after the last payload byte).
//   Results of an accepted byte are registered in the result queue and
//   presented from its head. Throughput: one rx byte per cycle while rx_stall
//   is low. The header's id lookup is a parallel compare against all window
//   entries in the cycle of the last size byte. Each byte yields at most two
//   results into a 4-entry result queue; rx_stall rises when fewer than two
//   entries are free, so a byte's two results (last payload byte plus
//   verdict) always fit. Stalling res holds the head result and backs up
//   into rx_stall. Reset: parser returns to header start, the id window is
//   emptied and the result queue cleared; the block is ready once reset ends.
module packet_deframer_with_dedupe
    import pdd_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  packet_status,
    output logic [63:0] message_id,
    output logic [7:0]  payload_byte,
    output logic        payload_last
);

    logic         rx_accept;
    logic         win_hit;
    logic         queue_full;
    pdd_win_req_t win_req;
    pdd_push_t    push;
    pdd_result_t  head;

    assign rx_accept = rx_valid && !rx_stall;
    assign rx_stall  = queue_full;

    // header/payload tracking and verdict selection
    pdd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (rx_accept),
        .rx_byte (rx_byte),
        .win_hit (win_hit),
        .win_req (win_req),
        .push    (push)
    );

    // seen-id window; records new data/check ids at header end
    pdd_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .win_req (win_req),
        .hit     (win_hit)
    );

    // result queue decouples the two-result beats from the output side
    pdd_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .head      (head),
        .full      (queue_full)
    );

    assign result_kind   = head.kind;
    assign packet_status = head.status;
    assign message_id    = head.id;
    assign payload_byte  = head.data;
    assign payload_last  = head.last;

endmodule

// ----- hw/rtl/pdd_checker.sv -----
// Port-level checks for the packet deframer, bound to the top level.
// Depends on pdd_pkg and packet_deframer_with_dedupe_macros.svh.
`include "packet_deframer_with_dedupe_macros.svh"

module pdd_checker
    import pdd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input logic [2:0]  result_kind,
    input logic [7:0]  packet_status,
    input logic [63:0] message_id,
    input logic [7:0]  payload_byte,
    input logic        payload_last
);

    `PDD_ASSERT_ALWAYS(a_kind_range, !res_valid || (result_kind <= KIND_UNKNOWN), "result kind out of range")
    `PDD_ASSERT_ALWAYS(a_last_on_payload, !(res_valid && payload_last) || (result_kind == KIND_PAYLOAD), "payload_last on a verdict")
    `PDD_ASSERT_ALWAYS(a_verdict_byte_zero, !res_valid || (result_kind == KIND_PAYLOAD) || (payload_byte == 8'd0), "verdict carries a data byte")
    `PDD_ASSERT_NEXT(a_stall_hold, res_valid && res_stall, res_valid && $stable(result_kind) && $stable(message_id) && $stable(packet_status), "stalled result changed")

endmodule

bind packet_deframer_with_dedupe pdd_checker u_pdd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .result_kind   (result_kind),
    .packet_status (packet_status),
    .message_id    (message_id),
    .payload_byte  (payload_byte),
    .payload_last  (payload_last)
);
